// File: hdl/tnrx_pkg.sv
`default_nettype none

package tnrx_pkg;

  localparam logic [7:0] CMD_IAC  = 8'd255;
  localparam logic [7:0] CMD_DONT = 8'd254;
  localparam logic [7:0] CMD_DO   = 8'd253;
  localparam logic [7:0] CMD_WONT = 8'd252;
  localparam logic [7:0] CMD_WILL = 8'd251;

  localparam logic [7:0] OPT_BINARY = 8'd0;
  localparam logic [7:0] OPT_ECHO   = 8'd1;
  localparam logic [7:0] OPT_SGA    = 8'd3;

  // words produced by one received byte: none, one data word, or a 3-word reply
  typedef struct packed {
    logic [1:0] cnt;
    logic       to_peer;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
  } tnrx_res_t;

endpackage

`default_nettype wire

// File: hdl/tnrx_if.sv
`default_nettype none

interface tnrx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface tnrx_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       to_peer;
  logic       last;

  modport source (output valid, output out_byte, output to_peer, output last, input ready);
  modport sink (input valid, input out_byte, input to_peer, input last, output ready);
endinterface

`default_nettype wire

// File: hdl/tnrx_parser.sv
`default_nettype none

module tnrx_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                take,
  input  logic [7:0]          rx_byte,
  output tnrx_pkg::tnrx_res_t res
);
  import tnrx_pkg::*;

  typedef enum logic [2:0] {
    ST_DATA,
    ST_IAC,
    ST_WILL,
    ST_DO,
    ST_SKIP
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   opt_ok;

  assign opt_ok = (rx_byte inside {OPT_BINARY, OPT_ECHO, OPT_SGA});

  always_comb begin
    state_nxt = ST_DATA;
    res       = '0;
    case (state_r)
      ST_IAC: begin
        if (rx_byte == CMD_IAC) begin
          res.cnt = 2'd1;
          res.b0  = CMD_IAC;
        end else if (rx_byte == CMD_WILL) begin
          state_nxt = ST_WILL;
        end else if (rx_byte == CMD_DO) begin
          state_nxt = ST_DO;
        end else if (rx_byte == CMD_WONT || rx_byte == CMD_DONT) begin
          state_nxt = ST_SKIP;
        end
      end
      ST_WILL, ST_DO: begin
        if (!opt_ok) begin
          res.cnt     = 2'd3;
          res.to_peer = 1'b1;
          res.b0      = CMD_IAC;
          res.b1      = (state_r == ST_WILL) ? CMD_DONT : CMD_WONT;
          res.b2      = rx_byte;
        end
      end
      ST_SKIP: begin
        state_nxt = ST_DATA;
      end
      default: begin
        if (rx_byte == CMD_IAC) begin
          state_nxt = ST_IAC;
        end else begin
          res.cnt = 2'd1;
          res.b0  = rx_byte;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_DATA;
    end else if (take) begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hdl/telnet_rx_option_filter_core.sv
`default_nettype none

// Channel  Dir  Payload                        Handshake
// in_ch    in   rx_byte[7:0]                   valid/ready
// out_ch   out  out_byte[7:0], to_peer, last   valid/ready
//
// One received byte per cycle unless out_ch stalls or a refusal drains; its words
// show on out_ch the cycle after acceptance. A 3-word refusal holds in_ch.ready low
// while the output buffer drains (the buffer is the limiting unit).
// rst_n is synchronous: parser returns to the data state and the buffer empties.
// Output stalls propagate straight back to in_ch.ready; no word is dropped.

module telnet_rx_option_filter_core (
  input  logic     clk,
  input  logic     rst_n,
  tnrx_in_if.sink  in_ch,
  tnrx_out_if.source out_ch
);
  import tnrx_pkg::*;

  tnrx_res_t  res;
  logic       take;
  logic       pop;
  logic [1:0] cnt_r;
  logic       peer_r;
  logic [7:0] b0_r;
  logic [7:0] b1_r;
  logic [7:0] b2_r;

  assign pop         = out_ch.valid && out_ch.ready;
  assign in_ch.ready = (cnt_r == 2'd0) || (cnt_r == 2'd1 && out_ch.ready);
  assign take        = in_ch.valid && in_ch.ready;

  tnrx_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .rx_byte (in_ch.rx_byte),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (take) begin
      cnt_r <= res.cnt;
    end else if (pop) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  // word buffer: head in b0_r, shifts down as words leave
  always_ff @(posedge clk) begin
    if (take) begin
      peer_r <= res.to_peer;
      b0_r   <= res.b0;
      b1_r   <= res.b1;
      b2_r   <= res.b2;
    end else if (pop) begin
      b0_r <= b1_r;
      b1_r <= b2_r;
    end
  end

  assign out_ch.valid    = (cnt_r != 2'd0);
  assign out_ch.out_byte = b0_r;
  assign out_ch.to_peer  = peer_r;
  assign out_ch.last     = (cnt_r == 2'd1);

endmodule

`default_nettype wire

// File: hdl/tnrx_checker.sv
`default_nettype none

module tnrx_sva_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       to_peer,
  input logic       last
);

  logic mid_reply_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_reply_r <= 1'b0;
    end else if (out_valid && out_ready) begin
      mid_reply_r <= to_peer && !last;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out word withdrawn while stalled");

  a_data_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !to_peer |-> last)
    else $error("data word not marked last");

  a_reply_cont: assert property (@(posedge clk) disable iff (!rst_n)
    mid_reply_r |-> out_valid && to_peer)
    else $error("reply to peer broken up");

  a_reply_head: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && to_peer && !mid_reply_r |-> out_byte == 8'd255 && !last)
    else $error("reply does not open with IAC");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input blocked with nothing pending");

endmodule

bind telnet_rx_option_filter_core tnrx_sva_checker u_tnrx_sva_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_byte  (out_ch.out_byte),
  .to_peer   (out_ch.to_peer),
  .last      (out_ch.last)
);

`default_nettype wire

// File: tb/tnrx_checker.sv
module tnrx_checker (
  input  logic clk,
  input  logic rst_n,
  tnrx_in_if   in_mon,
  tnrx_out_if  out_mon,
  output int   fail_cnt,
  output int   words_pending,
  output int   data_words,
  output int   refusal_cnt
);
  import tnrx_pkg::*;

  typedef enum logic [2:0] {
    PS_DATA,
    PS_IAC,
    PS_WILL,
    PS_DO,
    PS_SKIP
  } parse_st_e;

  typedef struct packed {
    logic [7:0] value;
    logic       to_peer;
    logic       last;
  } word_t;

  parse_st_e parse_st;
  word_t     exp_words[$];

  initial begin
    fail_cnt      = 0;
    words_pending = 0;
    data_words    = 0;
    refusal_cnt   = 0;
    parse_st      = PS_DATA;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_cnt++;
  endtask

  task automatic push_word(input logic [7:0] value, input logic to_peer, input logic last);
    word_t w;
    w.value   = value;
    w.to_peer = to_peer;
    w.last    = last;
    exp_words.push_back(w);
  endtask

  task automatic push_refusal(input logic [7:0] verb, input logic [7:0] opt);
    push_word(CMD_IAC, 1'b1, 1'b0);
    push_word(verb, 1'b1, 1'b0);
    push_word(opt, 1'b1, 1'b1);
    refusal_cnt++;
  endtask

  function automatic bit option_ok(input logic [7:0] opt);
    return opt == OPT_BINARY || opt == OPT_ECHO || opt == OPT_SGA;
  endfunction

  // advance the parser by one received byte and queue the words it causes
  task automatic predict_filter(input logic [7:0] b);
    case (parse_st)
      PS_IAC: begin
        if (b == CMD_IAC) begin
          push_word(CMD_IAC, 1'b0, 1'b1);
          parse_st = PS_DATA;
        end else if (b == CMD_WILL) begin
          parse_st = PS_WILL;
        end else if (b == CMD_DO) begin
          parse_st = PS_DO;
        end else if (b == CMD_WONT || b == CMD_DONT) begin
          parse_st = PS_SKIP;
        end else begin
          parse_st = PS_DATA;
        end
      end
      PS_WILL: begin
        parse_st = PS_DATA;
        if (!option_ok(b)) push_refusal(CMD_DONT, b);
      end
      PS_DO: begin
        parse_st = PS_DATA;
        if (!option_ok(b)) push_refusal(CMD_WONT, b);
      end
      PS_SKIP: begin
        parse_st = PS_DATA;
      end
      default: begin
        if (b == CMD_IAC) begin
          parse_st = PS_IAC;
        end else begin
          push_word(b, 1'b0, 1'b1);
          parse_st = PS_DATA;
        end
      end
    endcase
  endtask

  task automatic check_word();
    word_t want;
    if (exp_words.size() == 0) begin
      report_mismatch($sformatf("unexpected word %02h to_peer=%0b last=%0b",
                                out_mon.out_byte, out_mon.to_peer, out_mon.last));
      return;
    end
    want = exp_words.pop_front();
    if (out_mon.out_byte !== want.value)
      report_mismatch($sformatf("out_byte %02h, expected %02h",
                                out_mon.out_byte, want.value));
    if (out_mon.to_peer !== want.to_peer)
      report_mismatch($sformatf("to_peer %0b, expected %0b (byte %02h)",
                                out_mon.to_peer, want.to_peer, want.value));
    if (out_mon.last !== want.last)
      report_mismatch($sformatf("last %0b, expected %0b (byte %02h)",
                                out_mon.last, want.last, want.value));
    if (!want.to_peer) data_words++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      parse_st = PS_DATA;
      exp_words.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) predict_filter(in_mon.rx_byte);
      if (out_mon.valid && out_mon.ready) check_word();
    end
    words_pending <= exp_words.size();
  end

endmodule

// File: tb/tb.sv
module tb;
  import tnrx_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int PHASE_ITEMS  = 100;
  localparam int DRAIN_LIMIT  = 1000;
  localparam int TAIL_CYCLES  = 10;

  logic clk;
  logic rst_n;

  tnrx_in_if  in_ch();
  tnrx_out_if out_ch();

  int fail_cnt;
  int words_pending;
  int data_words;
  int refusal_cnt;

  int src_idle_pct = 0;
  int dst_idle_pct = 0;
  int sent_bytes   = 0;
  int stall_cnt    = 0;

  logic [7:0] directed_seq[$] = '{
    8'h00, 8'h7f, 8'h80,
    CMD_IAC, CMD_IAC,
    CMD_IAC, CMD_WILL, OPT_BINARY,
    CMD_IAC, CMD_DO, OPT_SGA,
    CMD_IAC, CMD_DO, 8'h18,
    CMD_IAC, CMD_WILL, 8'hff,
    CMD_IAC, CMD_DONT, 8'h05,
    CMD_IAC, CMD_WONT, OPT_ECHO,
    CMD_IAC, 8'hf1,
    CMD_IAC, 8'hfa,
    8'h55
  };

  telnet_rx_option_filter_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  tnrx_checker u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .fail_cnt      (fail_cnt),
    .words_pending (words_pending),
    .data_words    (data_words),
    .refusal_cnt   (refusal_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= dst_idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  initial begin
    while (stall_cnt < STALL_LIMIT) @(posedge clk);
    $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
    $display("FAILURE");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent_bytes++;
  endtask

  function automatic logic [7:0] pick_option();
    if ($urandom_range(1)) return 8'($urandom_range(255));
    case ($urandom_range(2))
      0:       return OPT_BINARY;
      1:       return OPT_ECHO;
      default: return OPT_SGA;
    endcase
  endfunction

  // mostly well-formed telnet sequences with random content, plus raw noise
  task automatic send_sequence();
    int kind;
    int n;
    kind = $urandom_range(99);
    if (kind < 35) begin
      send_byte(8'($urandom_range(254)));
    end else if (kind < 45) begin
      send_byte(CMD_IAC);
      send_byte(CMD_IAC);
    end else if (kind < 65) begin
      send_byte(CMD_IAC);
      send_byte($urandom_range(1) ? CMD_WILL : CMD_DO);
      send_byte(pick_option());
    end else if (kind < 75) begin
      send_byte(CMD_IAC);
      send_byte($urandom_range(1) ? CMD_WONT : CMD_DONT);
      send_byte(8'($urandom_range(255)));
    end else if (kind < 85) begin
      // any command below WILL is swallowed on its own
      send_byte(CMD_IAC);
      send_byte(8'($urandom_range(250)));
    end else begin
      n = $urandom_range(1, 3);
      repeat (n) send_byte(8'($urandom_range(255)));
    end
  endtask

  initial begin
    int drain;
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = 8'h00;
    out_ch.ready  = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    src_idle_pct = 35;
    dst_idle_pct = 71;
    foreach (directed_seq[i]) send_byte(directed_seq[i]);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_idle_pct = 35;
          dst_idle_pct = 71;
        end
        1: begin
          src_idle_pct = 71;
          dst_idle_pct = 35;
        end
        default: begin
          src_idle_pct = 0;
          dst_idle_pct = 0;
        end
      endcase
      while (sent_bytes < directed_seq.size() + (phase + 1) * PHASE_ITEMS) send_sequence();
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    drain = 0;
    while (words_pending != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    if (words_pending != 0) $display("%0d expected words never came out", words_pending);
    $display("sent %0d received bytes under three idle patterns (sender/receiver gaps)",
             sent_bytes);
    $display("host got %0d data words; peer got %0d option refusals", data_words, refusal_cnt);
    if (fail_cnt == 0 && words_pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/tnrx_pkg.sv
hdl/tnrx_if.sv
hdl/tnrx_parser.sv
hdl/telnet_rx_option_filter_core.sv
hdl/tnrx_checker.sv
tb/tnrx_checker.sv
tb/tb.sv
